// ----- design/setu_pkg.sv -----
// shared types and constants for the sprite effect timer table
package setu_pkg;

    localparam int SETU_SLOTS        = 4;
    localparam int SETU_QUEUE_DEPTH  = 2;
    localparam int SETU_MAX_RESULTS  = 4;
    localparam int SETU_ABSENT_BITS  = 4;

    // request kind codes on the input channel
    localparam logic [2:0] IN_TICK       = 3'd0;
    localparam logic [2:0] IN_BLINK      = 3'd1;
    localparam logic [2:0] IN_SCROLL     = 3'd2;
    localparam logic [2:0] IN_ANIM       = 3'd3;
    localparam logic [2:0] IN_STOP       = 3'd4;
    localparam logic [2:0] IN_DETACH_SPR = 3'd5;
    localparam logic [2:0] IN_DETACH_BG  = 3'd6;

    typedef enum logic [1:0] {
        EFF_NONE   = 2'd0,
        EFF_BLINK  = 2'd1,
        EFF_SCROLL = 2'd2,
        EFF_ANIM   = 2'd3
    } setu_effect_t;

    typedef enum logic [1:0] {
        ACT_REPLY   = 2'd0,
        ACT_VISIBLE = 2'd1,
        ACT_SCROLL  = 2'd2,
        ACT_TILE    = 2'd3
    } setu_action_t;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_DETACH_SPR,
        OP_DETACH_BG
    } setu_op_t;

    // classified command passed from the front to the back
    typedef struct packed {
        setu_op_t           op;
        setu_effect_t       effect;
        logic               reject;
        logic [7:0]         target;
        logic [7:0]         period;
        logic [7:0]         base_tile;
        logic [7:0]         frames;
        logic               once;
        logic signed [7:0]  dx;
        logic signed [7:0]  dy;
        logic [7:0]         slot_index;
        logic [SETU_ABSENT_BITS-1:0] absent;
    } setu_cmd_t;

    // one result without its last marker
    typedef struct packed {
        setu_action_t       action;
        logic [1:0]         slot;
        logic               no_slot;
        logic [7:0]         dest;
        logic [7:0]         value;
        logic signed [7:0]  move_x;
        logic signed [7:0]  move_y;
    } setu_result_t;

endpackage

// ----- design/setu_if.sv -----
// valid/ready channels for requests and results
interface setu_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [7:0]         target_id;
    logic [7:0]         period_ticks;
    logic [7:0]         start_tile;
    logic [7:0]         num_frames;
    logic               loop_mode;
    logic signed [7:0]  step_x;
    logic signed [7:0]  step_y;
    logic [7:0]         slot_index;
    logic [3:0]         absent_mask;

    modport source (
        output valid, kind, target_id, period_ticks, start_tile, num_frames,
               loop_mode, step_x, step_y, slot_index, absent_mask,
        input  ready
    );
    modport sink (
        input  valid, kind, target_id, period_ticks, start_tile, num_frames,
               loop_mode, step_x, step_y, slot_index, absent_mask,
        output ready
    );
endinterface

interface setu_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [1:0]         slot_number;
    logic               no_slot;
    logic [7:0]         dest_id;
    logic [7:0]         value;
    logic signed [7:0]  move_x;
    logic signed [7:0]  move_y;
    logic               last;

    modport source (
        output valid, action, slot_number, no_slot, dest_id, value, move_x, move_y,
               last,
        input  ready
    );
    modport sink (
        input  valid, action, slot_number, no_slot, dest_id, value, move_x, move_y,
               last,
        output ready
    );
endinterface

// ----- design/sprite_effect_timer_table_unit.sv -----
// top level of the sprite effect timer table
// The unit keeps SLOTS effect slots (blink, scroll, frame animation) and
// answers start requests with a slot number or a no-slot flag, frees slots on
// stop and detach requests, and on each tick request emits up to four
// commands in slot order, the final one marked last. A front end classifies
// requests into a two-entry command queue, so up to two requests are taken
// while the back end is busy. The back end walks the slot table one slot per
// cycle on ticks and detaches; a tick walk can pause while the result consumer
// holds ready low. Results leave through a registered output stage.
module sprite_effect_timer_table_unit
    import setu_pkg::*;
#(
    parameter int SLOTS = SETU_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    setu_in_if.sink     item,
    setu_out_if.source  result
);

    logic       q_push_valid, q_push_ready;
    setu_cmd_t  q_push_cmd;
    logic       q_pop_valid, q_pop_ready;
    setu_cmd_t  q_pop_cmd;

    // request classification
    setu_front u_front (
        .item       (item),
        .push_ready (q_push_ready),
        .push_valid (q_push_valid),
        .push_cmd   (q_push_cmd)
    );

    // command queue
    setu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_cmd   (q_push_cmd),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_cmd    (q_pop_cmd)
    );

    // slot table and sequencer
    setu_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_pop_valid),
        .cmd_ready (q_pop_ready),
        .cmd       (q_pop_cmd),
        .result    (result)
    );

`ifndef SYNTHESIS
    // a full queue always has a command to hand to the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> q_pop_valid)
        else $error("request stalled while queue is empty");

    // a start reply is always the single and final result of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.action == ACT_REPLY)) |-> result.last)
        else $error("start reply not marked last");

    // a rejected start reports slot zero and only on a reply
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.no_slot)
            |-> ((result.action == ACT_REPLY) && (result.slot_number == 2'd0)))
        else $error("bad no-slot result");
`endif

endmodule

// ----- design/setu_front.sv -----
// front end: accepts requests and turns them into table commands
module setu_front
    import setu_pkg::*;
(
    setu_in_if.sink     item,
    input  logic        push_ready,
    output logic        push_valid,
    output setu_cmd_t   push_cmd
);

    logic known;

    // decode the request kind
    always_comb
    begin
        known           = 1'b1;
        push_cmd.op     = OP_TICK;
        push_cmd.effect = EFF_NONE;
        case (item.kind)
            IN_TICK:
            begin
                push_cmd.op = OP_TICK;
            end
            IN_BLINK:
            begin
                push_cmd.op     = OP_START;
                push_cmd.effect = EFF_BLINK;
            end
            IN_SCROLL:
            begin
                push_cmd.op     = OP_START;
                push_cmd.effect = EFF_SCROLL;
            end
            IN_ANIM:
            begin
                push_cmd.op     = OP_START;
                push_cmd.effect = EFF_ANIM;
            end
            IN_STOP:
            begin
                push_cmd.op = OP_STOP;
            end
            IN_DETACH_SPR:
            begin
                push_cmd.op = OP_DETACH_SPR;
            end
            IN_DETACH_BG:
            begin
                push_cmd.op = OP_DETACH_BG;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase

        // operand preparation: period clamp, zero-frame reject, mode only for anim
        push_cmd.reject     = (item.kind == IN_ANIM) && (item.num_frames == 8'd0);
        push_cmd.target     = item.target_id;
        push_cmd.period     = (item.period_ticks == 8'd0) ? 8'd1 : item.period_ticks;
        push_cmd.base_tile  = item.start_tile;
        push_cmd.frames     = item.num_frames;
        push_cmd.once       = (item.kind == IN_ANIM) && item.loop_mode;
        push_cmd.dx         = item.step_x;
        push_cmd.dy         = item.step_y;
        push_cmd.slot_index = item.slot_index;
        push_cmd.absent     = item.absent_mask;
    end

    // unknown kinds are taken and dropped
    assign push_valid = item.valid && known;
    assign item.ready = push_ready;

endmodule

// ----- design/setu_queue.sv -----
// short command queue between front and back
module setu_queue
    import setu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  setu_cmd_t   push_cmd,
    output logic        pop_valid,
    input  logic        pop_ready,
    output setu_cmd_t   pop_cmd
);

    localparam int PTR_W = (SETU_QUEUE_DEPTH > 1) ? $clog2(SETU_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(SETU_QUEUE_DEPTH + 1);

    setu_cmd_t          entry_reg [SETU_QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(SETU_QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(SETU_QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(SETU_QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- design/setu_back.sv -----
// back end: slot table, slot walker and result register
module setu_back
    import setu_pkg::*;
#(
    parameter int SLOTS = SETU_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  setu_cmd_t   cmd,
    setu_out_if.source  result
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RES_W  = $clog2(SETU_MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        B_IDLE,
        B_EXEC,
        B_TICK,
        B_DETACH,
        B_FLUSH
    } state_t;

    state_t             state_reg, state_next;
    setu_cmd_t          cmd_reg;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [RES_W-1:0]   emit_cnt_reg, emit_cnt_next;
    logic               hold_valid_reg, hold_valid_next;
    setu_result_t       hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    setu_result_t       out_reg, out_next;
    logic               out_last_reg, out_last_next;

    // slot table
    logic [SLOTS-1:0]   active_reg;
    setu_effect_t       kind_reg [SLOTS];
    logic [7:0]         target_reg [SLOTS];
    logic [7:0]         period_reg [SLOTS];
    logic [7:0]         count_reg [SLOTS];
    logic [7:0]         prog_reg [SLOTS];
    logic               once_reg [SLOTS];
    logic [7:0]         base_reg [SLOTS];
    logic [7:0]         frames_reg [SLOTS];
    logic signed [7:0]  dx_reg [SLOTS];
    logic signed [7:0]  dy_reg [SLOTS];

    // table write controls
    logic               act_we, act_wval;
    logic [SLOT_W-1:0]  wslot;
    logic               kind_we;
    setu_effect_t       kind_wval;
    logic               start_we, tick_we;

    // current slot view and tick evaluation
    logic               any_free;
    logic [SLOT_W-1:0]  free_slot;
    logic [7:0]         cnt_inc, count_new, prog_new;
    logic [8:0]         prog_inc;
    logic               fire, gone, frame_wrap, emit, take, out_busy, stall, last_slot;
    logic               reject, detach_hit, push, push_last;
    setu_result_t       tick_res, reply;

    // lowest free slot
    always_comb
    begin
        any_free  = 1'b0;
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                any_free  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    // evaluate the slot under the walker for a tick
    always_comb
    begin
        cnt_inc    = count_reg[idx_reg] + 8'd1;
        fire       = (cnt_inc >= period_reg[idx_reg]);
        count_new  = fire ? 8'd0 : cnt_inc;
        gone       = (5'(idx_reg) < 5'(SETU_ABSENT_BITS)) && cmd_reg.absent[2'(idx_reg)];
        prog_inc   = {1'b0, prog_reg[idx_reg]} + 9'd1;
        frame_wrap = (prog_inc >= {1'b0, frames_reg[idx_reg]});
        emit       = active_reg[idx_reg] && fire && (kind_reg[idx_reg] != EFF_NONE) && !gone;
        take       = emit && (emit_cnt_reg < RES_W'(SETU_MAX_RESULTS));
        last_slot  = (idx_reg == SLOT_W'(SLOTS - 1));

        tick_res.slot    = 2'(idx_reg);
        tick_res.no_slot = 1'b0;
        tick_res.dest    = target_reg[idx_reg];
        tick_res.value   = 8'd0;
        tick_res.move_x  = 8'sd0;
        tick_res.move_y  = 8'sd0;
        prog_new         = prog_reg[idx_reg];
        case (kind_reg[idx_reg])
            EFF_BLINK:
            begin
                tick_res.action = ACT_VISIBLE;
                tick_res.value  = {7'd0, ~prog_reg[idx_reg][0]};
                if (emit)
                begin
                    prog_new = prog_inc[7:0];
                end
            end
            EFF_SCROLL:
            begin
                tick_res.action = ACT_SCROLL;
                tick_res.move_x = dx_reg[idx_reg];
                tick_res.move_y = dy_reg[idx_reg];
            end
            EFF_ANIM:
            begin
                tick_res.action = ACT_TILE;
                tick_res.value  = base_reg[idx_reg] + prog_reg[idx_reg];
                if (emit)
                begin
                    prog_new = frame_wrap ? 8'd0 : prog_inc[7:0];
                end
            end
            default:
            begin
                tick_res.action = ACT_REPLY;
            end
        endcase

        // detach match for the slot under the walker
        if (cmd_reg.op == OP_DETACH_BG)
        begin
            detach_hit = (kind_reg[idx_reg] == EFF_SCROLL);
        end
        else
        begin
            detach_hit = (kind_reg[idx_reg] == EFF_BLINK) || (kind_reg[idx_reg] == EFF_ANIM);
        end
        detach_hit = detach_hit && active_reg[idx_reg] && (target_reg[idx_reg] == cmd_reg.target);

        // start reply
        reject          = cmd_reg.reject || !any_free;
        reply.action    = ACT_REPLY;
        reply.slot      = reject ? 2'd0 : 2'(free_slot);
        reply.no_slot   = reject;
        reply.dest      = 8'd0;
        reply.value     = 8'd0;
        reply.move_x    = 8'sd0;
        reply.move_y    = 8'sd0;
    end

    assign out_busy = out_valid_reg && !result.ready;
    assign stall    = take && hold_valid_reg && out_busy;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        emit_cnt_next   = emit_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        cmd_ready       = 1'b0;
        act_we          = 1'b0;
        act_wval        = 1'b0;
        wslot           = idx_reg;
        kind_we         = 1'b0;
        kind_wval       = EFF_NONE;
        start_we        = 1'b0;
        tick_we         = 1'b0;
        push            = 1'b0;
        push_last       = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                cmd_ready     = 1'b1;
                idx_next      = '0;
                emit_cnt_next = '0;
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_TICK:       state_next = B_TICK;
                        OP_DETACH_SPR: state_next = B_DETACH;
                        OP_DETACH_BG:  state_next = B_DETACH;
                        default:       state_next = B_EXEC;
                    endcase
                end
            end
            B_EXEC:
            begin
                if (cmd_reg.op == OP_START)
                begin
                    hold_next       = reply;
                    hold_valid_next = 1'b1;
                    wslot           = free_slot;
                    if (!reject)
                    begin
                        start_we  = 1'b1;
                        act_we    = 1'b1;
                        act_wval  = 1'b1;
                        kind_we   = 1'b1;
                        kind_wval = cmd_reg.effect;
                    end
                    state_next = B_FLUSH;
                end
                else
                begin
                    wslot = SLOT_W'(cmd_reg.slot_index);
                    if (cmd_reg.slot_index < 8'(SLOTS))
                    begin
                        act_we  = 1'b1;
                        kind_we = 1'b1;
                    end
                    state_next = B_IDLE;
                end
            end
            B_TICK:
            begin
                if (!stall)
                begin
                    tick_we = active_reg[idx_reg];
                    if (active_reg[idx_reg] && fire && (kind_reg[idx_reg] != EFF_NONE))
                    begin
                        if (gone)
                        begin
                            act_we = 1'b1;
                        end
                        else if ((kind_reg[idx_reg] == EFF_ANIM) && frame_wrap
                                 && once_reg[idx_reg])
                        begin
                            act_we = 1'b1;
                        end
                    end
                    if (take)
                    begin
                        emit_cnt_next   = emit_cnt_reg + RES_W'(1);
                        push            = hold_valid_reg;
                        hold_next       = tick_res;
                        hold_valid_next = 1'b1;
                    end
                    if (last_slot)
                    begin
                        state_next = B_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end
            B_DETACH:
            begin
                if (detach_hit)
                begin
                    act_we  = 1'b1;
                    kind_we = 1'b1;
                end
                if (last_slot)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            B_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = B_IDLE;
                end
                else if (!out_busy)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // result register
        out_valid_next = out_valid_reg && !result.ready;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = hold_reg;
            out_last_next  = push_last;
        end
    end

    // state, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            idx_reg        <= '0;
            emit_cnt_reg   <= '0;
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            out_last_reg   <= 1'b0;
            active_reg     <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                kind_reg[i] <= EFF_NONE;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            emit_cnt_reg   <= emit_cnt_next;
            hold_valid_reg <= hold_valid_next;
            hold_reg       <= hold_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
            out_last_reg   <= out_last_next;
            if (act_we)
            begin
                active_reg[wslot] <= act_wval;
            end
            if (kind_we)
            begin
                kind_reg[wslot] <= kind_wval;
            end
        end
    end

    // command latch and slot payload
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (start_we)
        begin
            target_reg[wslot] <= cmd_reg.target;
            period_reg[wslot] <= cmd_reg.period;
            count_reg[wslot]  <= 8'd0;
            prog_reg[wslot]   <= 8'd0;
            once_reg[wslot]   <= cmd_reg.once;
            base_reg[wslot]   <= cmd_reg.base_tile;
            frames_reg[wslot] <= cmd_reg.frames;
            dx_reg[wslot]     <= cmd_reg.dx;
            dy_reg[wslot]     <= cmd_reg.dy;
        end
        if (tick_we)
        begin
            count_reg[idx_reg] <= count_new;
            prog_reg[idx_reg]  <= prog_new;
        end
    end

    // result channel
    assign result.valid       = out_valid_reg;
    assign result.action      = out_reg.action;
    assign result.slot_number = out_reg.slot;
    assign result.no_slot     = out_reg.no_slot;
    assign result.dest_id     = out_reg.dest;
    assign result.value       = out_reg.value;
    assign result.move_x      = out_reg.move_x;
    assign result.move_y      = out_reg.move_y;
    assign result.last        = out_last_reg;

endmodule

// ----- tb/tb_sprite_effect_timer_table_unit.sv -----
// self-checking testbench for the sprite effect timer table unit
`timescale 1ns / 1ps

module tb_sprite_effect_timer_table_unit;
    import setu_pkg::*;

    // kind code that the unit ignores
    localparam logic [2:0] IN_RESERVED = 3'd7;

    localparam int RANDOM_REQS  = 224;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 4 * (SETU_SLOTS + 2);
    localparam int PRINT_CAP    = 30;
    localparam int SRC_SIDE     = 0;
    localparam int SINK_SIDE    = 1;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        target_id;
        logic [7:0]        period_ticks;
        logic [7:0]        start_tile;
        logic [7:0]        num_frames;
        logic              loop_mode;
        logic signed [7:0] step_x;
        logic signed [7:0] step_y;
        logic [7:0]        slot_index;
        logic [3:0]        absent_mask;
    } effect_req_t;

    typedef struct packed {
        setu_result_t body;
        logic         last;
    } table_out_t;

    logic clk;
    logic rst_n;

    setu_in_if  item_bus ();
    setu_out_if result_bus ();

    sprite_effect_timer_table_unit #(.SLOTS(SETU_SLOTS)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    // shadow copy of the slot table
    logic         slot_on     [SETU_SLOTS];
    setu_effect_t slot_eff    [SETU_SLOTS];
    logic [7:0]   slot_tgt    [SETU_SLOTS];
    logic [7:0]   slot_per    [SETU_SLOTS];
    logic [7:0]   tick_cnt    [SETU_SLOTS];
    logic [7:0]   slot_prog   [SETU_SLOTS];
    logic         slot_once   [SETU_SLOTS];
    logic [7:0]   slot_base   [SETU_SLOTS];
    logic [7:0]   slot_frames [SETU_SLOTS];
    logic [7:0]   slot_dx     [SETU_SLOTS];
    logic [7:0]   slot_dy     [SETU_SLOTS];

    effect_req_t request_queue [$];
    table_out_t  awaited_outputs [$];

    int  calm_left [2];
    int  mismatches;
    int  accepted_reqs;
    int  total_reqs;
    int  outputs_seen;
    int  idle_cycles;
    int  ticks_sent;
    int  starts_sent;
    int  starts_rejected;
    int  in_gap;
    int  out_hold;
    bit  in_taken;
    bit  out_taken;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      outputs_seen, name, got, want));
        end
    endtask

    // gap length: mostly short, a few long, with calm stretches
    function automatic int pick_gap(input int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left[side] = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // request with every field random
    function automatic effect_req_t rand_req(input logic [2:0] k);
        effect_req_t r;
        r.kind         = k;
        r.target_id    = 8'($urandom);
        r.period_ticks = 8'($urandom);
        r.start_tile   = 8'($urandom);
        r.num_frames   = 8'($urandom);
        r.loop_mode    = 1'($urandom);
        r.step_x       = 8'($urandom);
        r.step_y       = 8'($urandom);
        r.slot_index   = 8'($urandom);
        r.absent_mask  = 4'($urandom);
        return r;
    endfunction

    // target drawn from a small pool so detach requests hit
    function automatic logic [7:0] pool_target();
        logic [7:0] t;
        if ($urandom_range(0, 99) >= 70)
            return 8'($urandom);
        t = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1)
            t = ~t;
        return t;
    endfunction

    task automatic queue_start(input logic [2:0] k, input logic [7:0] tgt,
                               input logic [7:0] per, input logic [7:0] first,
                               input logic [7:0] frames, input logic once,
                               input logic [7:0] sx, input logic [7:0] sy);
        effect_req_t r;
        r = rand_req(k);
        r.target_id    = tgt;
        r.period_ticks = per;
        r.start_tile   = first;
        r.num_frames   = frames;
        r.loop_mode    = once;
        r.step_x       = sx;
        r.step_y       = sy;
        request_queue.push_back(r);
    endtask

    task automatic queue_other(input logic [2:0] k, input logic [7:0] tgt,
                               input logic [7:0] sidx, input logic [3:0] absent);
        effect_req_t r;
        r = rand_req(k);
        r.target_id   = tgt;
        r.slot_index  = sidx;
        r.absent_mask = absent;
        request_queue.push_back(r);
    endtask

    // apply one request to the shadow table and queue the outputs it causes
    task automatic advance_effect_table(input effect_req_t rq);
        int         i;
        int         pick;
        logic [8:0] nxt;
        table_out_t o;
        table_out_t batch [$];

        case (rq.kind)
            IN_TICK:
            begin
                ticks_sent++;
                for (i = 0; i < SETU_SLOTS; i++)
                begin
                    if (!slot_on[i])
                        continue;
                    tick_cnt[i] = tick_cnt[i] + 8'd1;
                    if (tick_cnt[i] < slot_per[i])
                        continue;
                    tick_cnt[i] = 8'd0;
                    if (slot_eff[i] == EFF_NONE)
                        continue;
                    // target gone: free silently, kind kept
                    if (i < SETU_ABSENT_BITS && rq.absent_mask[i])
                    begin
                        slot_on[i] = 1'b0;
                        continue;
                    end
                    o = '0;
                    o.body.slot = i[1:0];
                    o.body.dest = slot_tgt[i];
                    case (slot_eff[i])
                        EFF_BLINK:
                        begin
                            o.body.action = ACT_VISIBLE;
                            o.body.value  = {7'd0, ~slot_prog[i][0]};
                            slot_prog[i]  = slot_prog[i] + 8'd1;
                        end
                        EFF_SCROLL:
                        begin
                            o.body.action = ACT_SCROLL;
                            o.body.move_x = slot_dx[i];
                            o.body.move_y = slot_dy[i];
                        end
                        default:
                        begin
                            o.body.action = ACT_TILE;
                            o.body.value  = slot_base[i] + slot_prog[i];
                            nxt = {1'b0, slot_prog[i]} + 9'd1;
                            // past the last frame: wrap, or free in play-once mode
                            if (nxt >= {1'b0, slot_frames[i]})
                            begin
                                nxt = 9'd0;
                                if (slot_once[i])
                                    slot_on[i] = 1'b0;
                            end
                            slot_prog[i] = nxt[7:0];
                        end
                    endcase
                    if (batch.size() < SETU_MAX_RESULTS)
                        batch.push_back(o);
                end
            end
            IN_BLINK, IN_SCROLL, IN_ANIM:
            begin
                starts_sent++;
                pick = -1;
                if (!(rq.kind == IN_ANIM && rq.num_frames == 8'd0))
                begin
                    for (i = SETU_SLOTS - 1; i >= 0; i--)
                    begin
                        if (!slot_on[i])
                            pick = i;
                    end
                end
                o = '0;
                o.body.action = ACT_REPLY;
                if (pick < 0)
                begin
                    o.body.no_slot = 1'b1;
                    starts_rejected++;
                end
                else
                begin
                    o.body.slot = pick[1:0];
                    if (rq.kind == IN_BLINK)
                        slot_eff[pick] = EFF_BLINK;
                    else if (rq.kind == IN_SCROLL)
                        slot_eff[pick] = EFF_SCROLL;
                    else
                        slot_eff[pick] = EFF_ANIM;
                    slot_tgt[pick]  = rq.target_id;
                    slot_per[pick]  = (rq.period_ticks == 8'd0) ? 8'd1 : rq.period_ticks;
                    tick_cnt[pick]  = 8'd0;
                    slot_prog[pick] = 8'd0;
                    slot_once[pick] = (rq.kind == IN_ANIM) ? rq.loop_mode : 1'b0;
                    if (rq.kind == IN_ANIM)
                    begin
                        slot_base[pick]   = rq.start_tile;
                        slot_frames[pick] = rq.num_frames;
                    end
                    if (rq.kind == IN_SCROLL)
                    begin
                        slot_dx[pick] = rq.step_x;
                        slot_dy[pick] = rq.step_y;
                    end
                    slot_on[pick] = 1'b1;
                end
                batch.push_back(o);
            end
            IN_STOP:
            begin
                if (rq.slot_index < SETU_SLOTS)
                begin
                    slot_on[rq.slot_index]  = 1'b0;
                    slot_eff[rq.slot_index] = EFF_NONE;
                end
            end
            IN_DETACH_SPR, IN_DETACH_BG:
            begin
                for (i = 0; i < SETU_SLOTS; i++)
                begin
                    if (slot_on[i] && slot_tgt[i] == rq.target_id &&
                        ((rq.kind == IN_DETACH_BG) ? (slot_eff[i] == EFF_SCROLL)
                                                   : (slot_eff[i] == EFF_BLINK ||
                                                      slot_eff[i] == EFF_ANIM)))
                    begin
                        slot_on[i]  = 1'b0;
                        slot_eff[i] = EFF_NONE;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // mark the final output of this request
        for (i = 0; i < batch.size(); i++)
        begin
            o = batch[i];
            o.last = (i == batch.size() - 1);
            awaited_outputs.push_back(o);
        end
    endtask

    // driver: requests and result backpressure change on the falling edge
    always @(negedge clk)
    begin : driver
        effect_req_t cur;
        if (!rst_n)
        begin
            item_bus.valid   <= 1'b0;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            // request side
            if (!(item_bus.valid && !in_taken))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    item_bus.valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    cur = request_queue.pop_front();
                    item_bus.kind         <= cur.kind;
                    item_bus.target_id    <= cur.target_id;
                    item_bus.period_ticks <= cur.period_ticks;
                    item_bus.start_tile   <= cur.start_tile;
                    item_bus.num_frames   <= cur.num_frames;
                    item_bus.loop_mode    <= cur.loop_mode;
                    item_bus.step_x       <= cur.step_x;
                    item_bus.step_y       <= cur.step_y;
                    item_bus.slot_index   <= cur.slot_index;
                    item_bus.absent_mask  <= cur.absent_mask;
                    item_bus.valid        <= 1'b1;
                    in_gap = pick_gap(SRC_SIDE);
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end

            // result side
            if (out_taken)
                out_hold = pick_gap(SINK_SIDE);
            else if (out_hold == 0 && $urandom_range(0, 99) < 3)
                out_hold = pick_gap(SINK_SIDE);
            if (out_hold > 0)
            begin
                result_bus.ready <= 1'b0;
                out_hold--;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // monitor: check results, then predict from the accepted request
    always @(posedge clk)
    begin : monitor
        table_out_t  want;
        effect_req_t seen_req;
        if (rst_n)
        begin
            out_taken = result_bus.valid && result_bus.ready;
            in_taken  = item_bus.valid && item_bus.ready;

            if (out_taken)
            begin
                if (awaited_outputs.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              outputs_seen));
                end
                else
                begin
                    want = awaited_outputs.pop_front();
                    check_field("action", 8'(result_bus.action), 8'(want.body.action));
                    check_field("slot_number", 8'(result_bus.slot_number),
                                8'(want.body.slot));
                    check_field("no_slot", 8'(result_bus.no_slot), 8'(want.body.no_slot));
                    check_field("dest_id", result_bus.dest_id, want.body.dest);
                    check_field("value", result_bus.value, want.body.value);
                    check_field("move_x", result_bus.move_x, want.body.move_x);
                    check_field("move_y", result_bus.move_y, want.body.move_y);
                    check_field("last", 8'(result_bus.last), 8'(want.last));
                end
                outputs_seen++;
            end

            if (in_taken)
            begin
                seen_req.kind         = item_bus.kind;
                seen_req.target_id    = item_bus.target_id;
                seen_req.period_ticks = item_bus.period_ticks;
                seen_req.start_tile   = item_bus.start_tile;
                seen_req.num_frames   = item_bus.num_frames;
                seen_req.loop_mode    = item_bus.loop_mode;
                seen_req.step_x       = item_bus.step_x;
                seen_req.step_y       = item_bus.step_y;
                seen_req.slot_index   = item_bus.slot_index;
                seen_req.absent_mask  = item_bus.absent_mask;
                advance_effect_table(seen_req);
                accepted_reqs++;
            end

            // watchdog on handshake activity
            if (in_taken || out_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin : stimulus
        effect_req_t rq;
        int          r;
        int          useful;

        rst_n = 1'b0;
        item_bus.valid        = 1'b0;
        item_bus.kind         = IN_TICK;
        item_bus.target_id    = 8'd0;
        item_bus.period_ticks = 8'd0;
        item_bus.start_tile   = 8'd0;
        item_bus.num_frames   = 8'd0;
        item_bus.loop_mode    = 1'b0;
        item_bus.step_x       = 8'd0;
        item_bus.step_y       = 8'd0;
        item_bus.slot_index   = 8'd0;
        item_bus.absent_mask  = 4'd0;
        result_bus.ready      = 1'b0;
        in_taken   = 1'b0;
        out_taken  = 1'b0;
        in_gap     = 0;
        out_hold   = 0;
        for (r = 0; r < SETU_SLOTS; r++)
        begin
            slot_on[r]  = 1'b0;
            slot_eff[r] = EFF_NONE;
        end

        // directed: quiet tick, ignored requests, rejects, every effect
        queue_other(IN_TICK, 8'h00, 8'h00, 4'b0000);
        queue_other(IN_STOP, 8'h00, 8'hFF, 4'b0000);
        queue_other(IN_STOP, 8'h00, 8'(SETU_SLOTS), 4'b0000);
        queue_other(IN_RESERVED, 8'h00, 8'h00, 4'b0000);
        queue_start(IN_ANIM, 8'h42, 8'd1, 8'd7, 8'd0, 1'b0, 8'h00, 8'h00);
        queue_start(IN_BLINK, 8'hFF, 8'd0, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00);
        queue_start(IN_SCROLL, 8'h00, 8'd1, 8'd0, 8'd0, 1'b0, 8'h80, 8'h7F);
        queue_start(IN_ANIM, 8'h80, 8'd2, 8'hFF, 8'd2, 1'b1, 8'h00, 8'h00);
        queue_start(IN_ANIM, 8'h01, 8'd255, 8'h00, 8'd255, 1'b0, 8'h00, 8'h00);
        queue_start(IN_BLINK, 8'h22, 8'd1, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00);
        queue_other(IN_TICK, 8'h00, 8'h00, 4'b0000);
        queue_other(IN_TICK, 8'h00, 8'h00, 4'b0000);
        queue_other(IN_TICK, 8'h00, 8'h00, 4'b0010);
        queue_other(IN_TICK, 8'h00, 8'h00, 4'b0000);
        queue_other(IN_DETACH_BG, 8'h00, 8'h00, 4'b0000);
        queue_start(IN_SCROLL, 8'h7F, 8'd1, 8'd0, 8'd0, 1'b0, 8'h7F, 8'hFF);
        queue_other(IN_DETACH_SPR, 8'hFF, 8'h00, 4'b0000);
        queue_other(IN_DETACH_BG, 8'h7F, 8'h00, 4'b0000);
        queue_other(IN_TICK, 8'h00, 8'h00, 4'b1111);
        queue_other(IN_STOP, 8'h00, 8'd3, 4'b0000);
        queue_start(IN_ANIM, 8'h05, 8'd1, 8'd10, 8'd1, 1'b0, 8'h00, 8'h00);
        queue_other(IN_TICK, 8'h00, 8'h00, 4'b0000);
        queue_other(IN_TICK, 8'h00, 8'h00, 4'b1110);
        queue_other(IN_STOP, 8'h00, 8'd0, 4'b0000);

        // random: mostly ticks and starts with small periods, some noise
        useful = 0;
        while (useful < RANDOM_REQS)
        begin
            rq = rand_req(IN_TICK);
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                if ($urandom_range(0, 99) < 75)
                    rq.absent_mask = 4'd0;
            end
            else if (r < 75)
            begin
                rq.kind = (r < 55) ? IN_BLINK : ((r < 65) ? IN_SCROLL : IN_ANIM);
                rq.target_id = pool_target();
                r = $urandom_range(0, 99);
                if (r < 60)
                    rq.period_ticks = 8'($urandom_range(0, 3));
                else if (r < 90)
                    rq.period_ticks = 8'($urandom_range(4, 10));
                r = $urandom_range(0, 99);
                if (r < 10)
                    rq.num_frames = 8'd0;
                else if (r < 70)
                    rq.num_frames = 8'($urandom_range(1, 5));
                else if (r >= 90)
                    rq.num_frames = 8'd255;
            end
            else if (r < 83)
            begin
                rq.kind = IN_STOP;
                if ($urandom_range(0, 99) < 80)
                    rq.slot_index = 8'($urandom_range(0, SETU_SLOTS - 1));
            end
            else if (r < 97)
            begin
                rq.kind = (r < 90) ? IN_DETACH_SPR : IN_DETACH_BG;
                rq.target_id = pool_target();
            end
            else
            begin
                rq.kind = IN_RESERVED;
            end
            if (rq.kind != IN_RESERVED && !(rq.kind == IN_STOP && rq.slot_index >= SETU_SLOTS))
                useful++;
            request_queue.push_back(rq);
        end
        total_reqs = request_queue.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_reqs < total_reqs)
            @(posedge clk);
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (awaited_outputs.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", awaited_outputs.size()));
        end

        $display("covered %0d requests: %0d ticks, %0d starts (%0d refused)",
                 accepted_reqs, ticks_sent, starts_sent, starts_rejected);
        $display("checked %0d results, %0d mismatches", outputs_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/setu_pkg.sv
design/setu_if.sv
design/setu_front.sv
design/setu_queue.sv
design/setu_back.sv
design/sprite_effect_timer_table_unit.sv
tb/tb_sprite_effect_timer_table_unit.sv
